[hw/rtl/ldif_lp_pkg.sv]
// Shared types, phase and status codes, and character helpers for the
// attribute line parser. No dependencies.

package ldif_lp_pkg;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_COLON  = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_VALUE  = 3'd4;
    localparam logic [2:0] PH_IGNORE = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_COLON = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_BAD_B64  = 2'd3;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PAD    = 8'h3D;
    localparam logic [7:0] CH_MARKER = 8'h01;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  withheld_spaces;
        logic [1:0]  group_position;
        logic [5:0]  carry_bits;
        logic [1:0]  error_code;
        logic        base64_mode;
        logic [11:0] value_count;
    } parse_state_t;

    typedef struct packed {
        logic        has_byte;
        logic        in_value;
        logic [7:0]  out_byte;
        logic [3:0]  space_run;
        logic        line_done;
        logic [1:0]  status;
        logic        value_is_base64;
        logic [11:0] value_length;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase: PH_LEAD, withheld_spaces: 4'd0, group_position: 2'd0,
        carry_bits: 6'd0, error_code: ST_OK, base64_mode: 1'b0,
        value_count: 12'd0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    // Returns {invalid, sextet}; invalid is set for bytes outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            d = c - 8'h41;
            return {1'b0, d[5:0]};
        end else if (c inside {[8'h61:8'h7A]}) begin
            d = c - 8'h47;
            return {1'b0, d[5:0]};
        end else if (c inside {[8'h30:8'h39]}) begin
            d = c + 8'h04;
            return {1'b0, d[5:0]};
        end else if (c == 8'h2B) begin
            return 7'h3E;
        end else if (c == 8'h2F) begin
            return 7'h3F;
        end
        return 7'h40;
    endfunction

endpackage

[hw/rtl/ldif_lp_step.sv]
// Next-state and result logic for one byte of an attribute line.
// Depends on ldif_lp_pkg.

module ldif_lp_step
    import ldif_lp_pkg::*;
#(
    parameter int MAX_VALUE_LEN = 4095,
    parameter int MAX_SPACE_RUN = 15
) (
    input  parse_state_t  cur,
    input  logic [7:0]    char_in,
    input  logic          end_of_line,
    output parse_state_t  nxt,
    output parse_result_t res,
    output logic          produce
);

    localparam logic [11:0] LEN_LIMIT =
        (MAX_VALUE_LEN < 4095) ? 12'(MAX_VALUE_LEN) : 12'd4095;
    localparam logic [3:0] SPACE_LIMIT =
        (MAX_SPACE_RUN < 15) ? 4'(MAX_SPACE_RUN) : 4'd15;

    parse_state_t  st;
    parse_result_t r;
    logic          consumed;
    logic          emit;
    logic [6:0]    sx;

    always_comb begin
        st       = cur;
        r        = '0;
        consumed = 1'b0;
        emit     = 1'b0;
        sx       = sextet_of(char_in);

        // The byte right after the colon decides between plain and base64 value.
        if (st.phase == PH_COLON) begin
            st.phase = PH_SKIP;
            if (char_in == CH_COLON) begin
                st.base64_mode = 1'b1;
                consumed       = 1'b1;
            end
        end

        if (!consumed) begin
            case (st.phase)
                PH_LEAD, PH_TYPE: begin
                    if (char_in == CH_COLON) begin
                        st.withheld_spaces = 4'd0;
                        st.phase           = PH_COLON;
                    end else if (is_ws(char_in)) begin
                        if (st.phase == PH_TYPE && st.withheld_spaces < SPACE_LIMIT) begin
                            st.withheld_spaces = st.withheld_spaces + 4'd1;
                        end
                    end else begin
                        r.has_byte         = 1'b1;
                        r.out_byte         = char_in;
                        r.space_run        = st.withheld_spaces;
                        st.withheld_spaces = 4'd0;
                        st.phase           = PH_TYPE;
                    end
                end
                PH_SKIP, PH_VALUE: begin
                    if (!(st.phase == PH_SKIP && is_ws(char_in))) begin
                        st.phase = PH_VALUE;
                        if (char_in != CH_MARKER) begin
                            if (!st.base64_mode) begin
                                r.has_byte = 1'b1;
                                r.out_byte = char_in;
                                emit       = 1'b1;
                            end else if (char_in == CH_PAD) begin
                                if (st.group_position < 2'd2) begin
                                    st.error_code = ST_BAD_B64;
                                end
                                st.phase          = PH_IGNORE;
                                st.group_position = 2'd0;
                            end else if (sx[6]) begin
                                st.error_code     = ST_BAD_B64;
                                st.phase          = PH_IGNORE;
                                st.group_position = 2'd0;
                            end else begin
                                case (st.group_position)
                                    2'd0: begin
                                        st.carry_bits = sx[5:0];
                                    end
                                    2'd1: begin
                                        r.out_byte    = {st.carry_bits, sx[5:4]};
                                        st.carry_bits = {2'b00, sx[3:0]};
                                        emit          = 1'b1;
                                    end
                                    2'd2: begin
                                        r.out_byte    = {st.carry_bits[3:0], sx[5:2]};
                                        st.carry_bits = {4'b0000, sx[1:0]};
                                        emit          = 1'b1;
                                    end
                                    default: begin
                                        r.out_byte    = {st.carry_bits[1:0], sx[5:0]};
                                        st.carry_bits = 6'd0;
                                        emit          = 1'b1;
                                    end
                                endcase
                                st.group_position = st.group_position + 2'd1;
                                r.has_byte        = emit;
                            end
                            if (emit) begin
                                r.in_value = 1'b1;
                                if (st.value_count < LEN_LIMIT) begin
                                    st.value_count = st.value_count + 12'd1;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        r.line_done       = end_of_line;
        r.value_is_base64 = st.base64_mode;
        r.value_length    = st.value_count;
        if (end_of_line) begin
            case (st.phase)
                PH_LEAD, PH_TYPE:  r.status = ST_NO_COLON;
                PH_COLON, PH_SKIP: r.status = ST_EMPTY;
                PH_VALUE: begin
                    r.status = (st.base64_mode && st.group_position != 2'd0) ?
                               ST_BAD_B64 : ST_OK;
                end
                default:           r.status = st.error_code;
            endcase
        end

        nxt     = end_of_line ? STATE_RESET : st;
        res     = r;
        produce = r.has_byte | end_of_line;
    end

endmodule

[hw/rtl/ldif_attribute_line_parser.sv]
// Top level of the attribute line parser: parse state and result register
// around the per-byte step logic. Depends on ldif_lp_pkg and ldif_lp_step.
//
//  Channel | Ports                                         | Moves
//  --------+-----------------------------------------------+----------------------------
//  s_      | s_valid s_ready s_char_in s_end_of_line       | one line byte per request
//  m_      | m_valid m_ready m_has_byte ... m_value_length | zero or one result per byte
//
// One byte is accepted per clock while s_ready is high; any result is on m_ the next cycle.
// The parse state and the result register are loaded in the same cycle that accepts a byte.
// s_ready is low only while a result is held and m_ready is low.
// aresetn is synchronous and active low; it empties the result register and
// returns the parser to the leading whitespace phase.

module ldif_attribute_line_parser
    import ldif_lp_pkg::*;
#(
    parameter int MAX_VALUE_LEN = 4095,
    parameter int MAX_SPACE_RUN = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_in,
    input  logic        s_end_of_line,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_has_byte,
    output logic        m_in_value,
    output logic [7:0]  m_out_byte,
    output logic [3:0]  m_space_run,
    output logic        m_line_done,
    output logic [1:0]  m_status,
    output logic        m_value_is_base64,
    output logic [11:0] m_value_length
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t res_reg;
    parse_result_t res_next;
    logic          m_valid_reg;
    logic          produce;
    logic          accept;

    ldif_lp_step #(
        .MAX_VALUE_LEN(MAX_VALUE_LEN),
        .MAX_SPACE_RUN(MAX_SPACE_RUN)
    ) u_step (
        .cur        (state_reg),
        .char_in    (s_char_in),
        .end_of_line(s_end_of_line),
        .nxt        (state_next),
        .res        (res_next),
        .produce    (produce)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= produce;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_has_byte        = res_reg.has_byte;
    assign m_in_value        = res_reg.in_value;
    assign m_out_byte        = res_reg.out_byte;
    assign m_space_run       = res_reg.space_run;
    assign m_line_done       = res_reg.line_done;
    assign m_status          = res_reg.status;
    assign m_value_is_base64 = res_reg.value_is_base64;
    assign m_value_length    = res_reg.value_length;

endmodule

[hw/rtl/ldif_lp_checker.sv]
// Port-level checks for the attribute line parser, bound to its top level.
// Depends on ldif_lp_pkg and ldif_attribute_line_parser.

module ldif_lp_checker
    import ldif_lp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_has_byte,
    input logic        m_in_value,
    input logic [7:0]  m_out_byte,
    input logic [3:0]  m_space_run,
    input logic        m_line_done,
    input logic [1:0]  m_status,
    input logic [11:0] m_value_length
);

    // A stalled result request holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_status)
            && $stable(m_value_length) && $stable(m_line_done))
        else $error("stalled result changed");

    // Every result carries a byte, ends a line, or both.
    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_has_byte || m_line_done)
        else $error("empty result");

    // Without a byte the byte fields are zero; value bytes carry no space run.
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (!m_has_byte || m_in_value) |-> m_space_run == 4'd0
            && (m_has_byte || (m_out_byte == 8'd0 && !m_in_value)))
        else $error("byte fields not cleared");

    // Status is only reported at the end of a line.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_line_done |-> m_status == ST_OK)
        else $error("status before end of line");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ldif_attribute_line_parser ldif_lp_checker u_ldif_lp_checker (.*);
